[sv/fla_pkg.sv]
package fla_pkg;

    localparam int ENTRIES    = 1024;
    localparam int IDX_W      = 10;
    localparam int PSIZE_W    = 11;
    localparam int LINK_W     = IDX_W + 1;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [PSIZE_W-1:0] ENTRIES_SZ = PSIZE_W'(ENTRIES);

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORMAT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENTINEL_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENTINEL_SLOT = 2'd2;

    typedef struct packed {
        logic [PSIZE_W-1:0] pool_size;
        logic               sentinel_enable;
        logic [IDX_W-1:0]   sentinel_slot;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

[sv/fla_req_if.sv]
interface fla_req_if;
    import fla_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink (input valid, input func, input slot_index, output ready);

endinterface

[sv/fla_rsp_if.sv]
interface fla_rsp_if;
    import fla_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;

    modport source (output valid, output status, output granted_index, input ready);
    modport sink (input valid, input status, input granted_index, output ready);

endinterface

[sv/free_list_index_allocator.sv]
// Slot allocator over a singly linked free list kept in a 1024-entry link memory.
// Release, the unassigned function code and an allocate that finds the pool empty
// answer straight from S_IDLE; an allocate that hands out a slot passes through
// S_ALLOC because the head's link must come out of the registered-read memory
// before the head moves. Format walks min(pool_size, 1024) slots with one counter
// and compare unit, one slot per cycle, writing a link for each but the sentinel.
// One item is worked at a time; the result sits in an output register, and the
// next item is taken as soon as that register is free or being drained.
// Link memory contents are undefined until a format or release writes them.
module free_list_index_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    fla_req_if.sink                         req,
    fla_rsp_if.source                       rsp,
    input  logic                            cfg_wr_en,
    input  logic [fla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fla_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fla_pkg::*;

    cfg_t              cfg_reg, cfg_next;
    ram_req_t          ram_req;
    logic [LINK_W-1:0] ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POOL_SIZE:     cfg_next.pool_size       = cfg_data[PSIZE_W-1:0];
                REG_SENTINEL_EN:   cfg_next.sentinel_enable = cfg_data[0];
                REG_SENTINEL_SLOT: cfg_next.sentinel_slot   = cfg_data[IDX_W-1:0];
                default:           cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_size       <= ENTRIES_SZ;
            cfg_reg.sentinel_enable <= 1'b0;
            cfg_reg.sentinel_slot   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    fla_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

[sv/fla_ram.sv]
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/fla_core.sv]
module fla_core (
    input  logic                        clk,
    input  logic                        rst_n,
    fla_req_if.sink                     req,
    fla_rsp_if.source                   rsp,
    input  fla_pkg::cfg_t               cfg,
    output fla_pkg::ram_req_t           ram_req,
    input  logic [fla_pkg::LINK_W-1:0]  ram_rdata
);
    import fla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ALLOC = 3'b010,
        S_FMT   = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_index_reg, head_index_next;
    logic                head_valid_reg, head_valid_next;
    logic [PSIZE_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic                have_last_reg, have_last_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [IDX_W-1:0]    granted_reg, granted_next;

    logic [PSIZE_W-1:0]  eff_size;
    logic                accept;
    logic                cnt_in_pool;
    logic                is_sentinel;

    assign eff_size    = (cfg.pool_size > ENTRIES_SZ) ? ENTRIES_SZ : cfg.pool_size;
    assign req.ready   = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept      = req.valid && req.ready;
    assign cnt_in_pool = cnt_reg < eff_size;
    assign is_sentinel = cfg.sentinel_enable && (cnt_reg[IDX_W-1:0] == cfg.sentinel_slot);

    always_comb
    begin
        state_next      = state_reg;
        head_index_next = head_index_reg;
        head_valid_next = head_valid_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        have_last_next  = have_last_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        status_next     = status_reg;
        granted_next    = granted_reg;
        ram_req         = '0;
        ram_req.raddr   = head_index_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_ALLOC:
                        begin
                            if (!head_valid_reg)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = STATUS_EMPTY;
                                granted_next   = '0;
                            end
                            else
                            begin
                                // link of the head is read at this edge
                                state_next = S_ALLOC;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            rsp_valid_next = 1'b1;
                            granted_next   = '0;
                            if ({1'b0, req.slot_index} >= eff_size)
                            begin
                                status_next = STATUS_INVALID;
                            end
                            else
                            begin
                                status_next     = STATUS_OK;
                                ram_req.we      = 1'b1;
                                ram_req.waddr   = req.slot_index;
                                ram_req.wdata   = {head_valid_reg, head_index_reg};
                                head_index_next = req.slot_index;
                                head_valid_next = 1'b1;
                            end
                        end
                        FUNC_FORMAT:
                        begin
                            cnt_next       = '0;
                            last_next      = '0;
                            have_last_next = 1'b0;
                            state_next     = S_FMT;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = STATUS_OK;
                            granted_next   = '0;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                head_index_next = ram_rdata[IDX_W-1:0];
                head_valid_next = ram_rdata[IDX_W];
                rsp_valid_next  = 1'b1;
                status_next     = STATUS_OK;
                granted_next    = head_index_reg;
                state_next      = S_IDLE;
            end
            S_FMT:
            begin
                if (cnt_in_pool)
                begin
                    if (!is_sentinel)
                    begin
                        ram_req.we     = 1'b1;
                        ram_req.waddr  = cnt_reg[IDX_W-1:0];
                        ram_req.wdata  = {have_last_reg, last_reg};
                        last_next      = cnt_reg[IDX_W-1:0];
                        have_last_next = 1'b1;
                    end
                    cnt_next = cnt_reg + PSIZE_W'(1);
                end
                else
                begin
                    head_index_next = last_reg;
                    head_valid_next = have_last_reg;
                    rsp_valid_next  = 1'b1;
                    status_next     = STATUS_OK;
                    granted_next    = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_index_reg <= '0;
            head_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_index_reg <= head_index_next;
            head_valid_reg <= head_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        last_reg      <= last_next;
        have_last_reg <= have_last_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.granted_index = granted_reg;

endmodule
